### design/plink_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plink_pkg
// Shared types and constants of the panel link packet handler.
// ----------------------------------------------------------------------------
package plink_pkg;

  // widths
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 4;
  localparam int LIMIT_W = 4;
  localparam int ADDR_W  = 2;

  // packet geometry
  localparam int PKT_BYTES = 9;
  localparam logic [POS_W-1:0] POS_CSUM = 4'd8;
  localparam logic [POS_W-1:0] POS_TAIL_LAST = 4'd7;
  localparam logic [POS_W-1:0] POS_BUTTON = 4'd1;
  localparam logic [POS_W-1:0] POS_SECOND = 4'd2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POS_W-1:0] pos_t;

  // configuration register indexes
  localparam logic [ADDR_W-1:0] REG_SYNC  = 2'd0;
  localparam logic [ADDR_W-1:0] REG_SEED  = 2'd1;
  localparam logic [ADDR_W-1:0] REG_LIMIT = 2'd2;

  // configuration reset values
  localparam byte_t SYNC_RESET = 8'hB0;
  localparam byte_t SEED_RESET = 8'h55;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd10;

  // panel button codes: power, step buttons for tx bytes 1..6, second byte step
  localparam byte_t BTN_POWER    = 8'h01;
  localparam byte_t STEP_BTN [6] = '{8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80};
  localparam byte_t SECOND_STEP  = 8'h21;

  // transmit packet after reset
  localparam byte_t TX_RESET [PKT_BYTES] = '{
    8'h0B, 8'h07, 8'h00, 8'h28, 8'h0F, 8'h20, 8'h04, 8'h00, 8'hC2
  };

  // configuration seen by the datapath
  typedef struct packed {
    byte_t               sync_byte;
    byte_t               checksum_seed;
    logic [LIMIT_W-1:0]  repeat_limit;
  } cfg_t;

  // link control to the command unit
  typedef struct packed {
    logic  act;
    byte_t button;
    byte_t second;
    pos_t  rd_pos;
  } cmd_req_t;

  // command unit status back to the link control
  typedef struct packed {
    byte_t tx_byte;
    logic  updated;
    logic  suppressed;
  } cmd_rsp_t;

endpackage

### design/plink_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plink_if
// Handshake channels of the panel link packet handler: received words,
// result words and configuration writes.
// ----------------------------------------------------------------------------
interface plink_rx_if import plink_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface plink_res_if import plink_pkg::*; ();
  logic        valid;
  logic        ready;
  byte_t       tx_byte;
  logic [1:0]  link_phase;
  logic        packet_end;
  logic        checksum_error;
  logic        command_updated;
  logic        press_suppressed;

  modport source (output valid, output tx_byte, output link_phase, output packet_end,
                  output checksum_error, output command_updated,
                  output press_suppressed, input ready);
  modport sink (input valid, input tx_byte, input link_phase, input packet_end,
                input checksum_error, input command_updated,
                input press_suppressed, output ready);
endinterface

interface plink_cfg_if import plink_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] addr;
  byte_t             data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

### design/plink_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plink_cfg
// Configuration registers: sync byte, checksum seed and repeat limit.
// ----------------------------------------------------------------------------
module plink_cfg import plink_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  plink_cfg_if.sink     cfg,
  output cfg_t          cfg_s
);

  byte_t              sync_byte;
  byte_t              checksum_seed;
  logic [LIMIT_W-1:0] repeat_limit;

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register decode
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte     <= SYNC_RESET;
      checksum_seed <= SEED_RESET;
      repeat_limit  <= LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_SYNC:  sync_byte     <= cfg.data;
        REG_SEED:  checksum_seed <= cfg.data;
        REG_LIMIT: repeat_limit  <= cfg.data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_s = '{sync_byte: sync_byte, checksum_seed: checksum_seed,
                   repeat_limit: repeat_limit};

endmodule

### design/plink_cmd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plink_cmd
// Transmit packet store and button command decode. At the end of a good
// packet it applies the button code, rewrites the transmit checksum and
// tracks the repeat counter.
// ----------------------------------------------------------------------------
module plink_cmd import plink_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg_s,
  input  cmd_req_t req,
  output cmd_rsp_t rsp
);

  localparam int    LAST_DATA  = PKT_BYTES - 2;

  byte_t              tx_pkt [PKT_BYTES];
  byte_t              tx_next [PKT_BYTES];
  logic [LIMIT_W-1:0] repeat_count;
  logic [LIMIT_W-1:0] repeat_count_next;
  logic               upd;
  logic               sup;
  logic               is_step;
  logic               is_extra;
  pos_t               step_idx;
  byte_t              tx_sum;

  // step button decode
  always_comb begin
    is_step  = 1'b1;
    step_idx = POS_BUTTON;
    case (req.button)
      STEP_BTN[0]: step_idx = 4'd1;
      STEP_BTN[1]: step_idx = 4'd2;
      STEP_BTN[2]: step_idx = 4'd3;
      STEP_BTN[3]: step_idx = 4'd4;
      STEP_BTN[4]: step_idx = 4'd5;
      STEP_BTN[5]: step_idx = 4'd6;
      default:     is_step = 1'b0;
    endcase
    is_extra = (req.second == SECOND_STEP);
  end

  // command action and new checksum
  always_comb begin
    tx_next           = tx_pkt;
    repeat_count_next = repeat_count;
    upd               = 1'b0;
    sup               = 1'b0;
    tx_sum            = cfg_s.checksum_seed;
    if (req.button == BTN_POWER) begin
      for (int i = 1; i <= LAST_DATA; i++) begin
        tx_next[i] = '0;
      end
      upd = 1'b1;
    end else if (repeat_count != '0 && (is_step || is_extra)) begin
      sup = 1'b1;
      if (repeat_count >= cfg_s.repeat_limit) begin
        repeat_count_next = '0;
      end else begin
        repeat_count_next = repeat_count + 4'd1;
      end
    end else if (is_step) begin
      tx_next[step_idx] = tx_pkt[step_idx] + 8'd1;
      upd = 1'b1;
    end else if (is_extra) begin
      tx_next[LAST_DATA] = tx_pkt[LAST_DATA] + 8'd1;
      upd = 1'b1;
    end else begin
      repeat_count_next = '0;
    end
    for (int i = 0; i <= LAST_DATA; i++) begin
      tx_sum = tx_sum + tx_next[i];
    end
    if (upd) begin
      tx_next[PKT_BYTES-1] = tx_sum;
      repeat_count_next    = 4'd1;
    end
  end

  // packet store and repeat counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PKT_BYTES; i++) begin
        tx_pkt[i] <= TX_RESET[i];
      end
      repeat_count <= '0;
    end else if (req.act) begin
      tx_pkt       <= tx_next;
      repeat_count <= repeat_count_next;
    end
  end

  assign rsp = '{tx_byte: tx_pkt[req.rd_pos], updated: req.act & upd,
                 suppressed: req.act & sup};

endmodule

### design/panel_link_packet_handler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panel_link_packet_handler
// Full-duplex 9-byte panel link: one received word in, one transmit word out.
// ----------------------------------------------------------------------------
// Takes one received word per cycle unless the result channel stalls and returns
// one result word for it, through the input register and then the result register.
// The phase, byte position and running checksum are updated once per word in the
// cycle the word moves from the input register to the result register, so
// back-to-back words run at full rate. Link phases: hunt for the sync byte, skip
// the 8-byte tail, take one packet without acting, then act on every good packet.
// Transmit packet changes made at a packet end show from the next packet on.
// Configuration is to be written through the cfg channel only while idle, which
// the block does not enforce; a new checksum seed takes effect at the next packet start.
// ----------------------------------------------------------------------------
module panel_link_packet_handler import plink_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  plink_rx_if.sink     rx,
  plink_res_if.source  res,
  plink_cfg_if.sink    cfg
);

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_TAIL  = 2'd1,
    PH_FIRST = 2'd2,
    PH_RUN   = 2'd3
  } phase_t;

  cfg_t     cfg_s;
  cmd_req_t cmd_req;
  cmd_rsp_t cmd_rsp;

  // input register
  logic  in_valid;
  byte_t rx_q;

  // link state
  phase_t phase, phase_next;
  pos_t   byte_pos, byte_pos_next;
  pos_t   pos;
  byte_t  running_sum, running_sum_next;
  byte_t  button_byte, button_byte_next;
  byte_t  second_byte, second_byte_next;
  logic   end_flag;
  logic   err_flag;
  logic   act_flag;
  logic   advance;

  // result register
  logic       res_valid;
  byte_t      res_tx;
  logic [1:0] res_phase;
  logic       res_end;
  logic       res_err;
  logic       res_upd;
  logic       res_sup;

  plink_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_s (cfg_s)
  );

  plink_cmd u_cmd (
    .clk   (clk),
    .rst   (rst),
    .cfg_s (cfg_s),
    .req   (cmd_req),
    .rsp   (cmd_rsp)
  );

  // handshake
  assign advance  = in_valid && (!res_valid || res.ready);
  assign rx.ready = !in_valid || advance;

  // link phase and packet tracking
  always_comb begin
    pos              = (byte_pos <= POS_CSUM) ? byte_pos : '0;
    phase_next       = phase;
    byte_pos_next    = byte_pos;
    running_sum_next = running_sum;
    button_byte_next = button_byte;
    second_byte_next = second_byte;
    end_flag         = 1'b0;
    err_flag         = 1'b0;
    act_flag         = 1'b0;
    case (phase)
      PH_HUNT: begin
        if (rx_q == cfg_s.sync_byte) begin
          phase_next    = PH_TAIL;
          byte_pos_next = '0;
        end
      end
      PH_TAIL: begin
        if (pos >= POS_TAIL_LAST) begin
          end_flag         = 1'b1;
          phase_next       = PH_FIRST;
          byte_pos_next    = '0;
          running_sum_next = cfg_s.checksum_seed;
        end else begin
          byte_pos_next = pos + 4'd1;
        end
      end
      default: begin
        if (pos < POS_CSUM) begin
          running_sum_next = running_sum + rx_q;
          if (pos == POS_BUTTON) begin
            button_byte_next = rx_q;
          end
          if (pos == POS_SECOND) begin
            second_byte_next = rx_q;
          end
          byte_pos_next = pos + 4'd1;
        end else begin
          end_flag = 1'b1;
          if (phase == PH_RUN) begin
            if (running_sum != rx_q) begin
              err_flag = 1'b1;
            end else begin
              act_flag = 1'b1;
            end
          end
          phase_next       = PH_RUN;
          byte_pos_next    = '0;
          running_sum_next = cfg_s.checksum_seed;
        end
      end
    endcase
  end

  // command unit request
  assign cmd_req = '{act: advance & act_flag, button: button_byte, second: second_byte,
                     rd_pos: (phase == PH_HUNT) ? '0 : pos};

  // state, input and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      res_valid   <= 1'b0;
      phase       <= PH_HUNT;
      byte_pos    <= '0;
      running_sum <= SEED_RESET;
      button_byte <= '0;
      second_byte <= '0;
    end else begin
      if (rx.valid && rx.ready) begin
        in_valid <= 1'b1;
        rx_q     <= rx.rx_byte;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        res_valid   <= 1'b1;
        res_tx      <= cmd_rsp.tx_byte;
        res_phase   <= phase;
        res_end     <= end_flag;
        res_err     <= err_flag;
        res_upd     <= cmd_rsp.updated;
        res_sup     <= cmd_rsp.suppressed;
        phase       <= phase_next;
        byte_pos    <= byte_pos_next;
        running_sum <= running_sum_next;
        button_byte <= button_byte_next;
        second_byte <= second_byte_next;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result word
  assign res.valid            = res_valid;
  assign res.tx_byte          = res_tx;
  assign res.link_phase       = res_phase;
  assign res.packet_end       = res_end;
  assign res.checksum_error   = res_err;
  assign res.command_updated  = res_upd;
  assign res.press_suppressed = res_sup;

endmodule
